// File: rtl/tphs_pkg.sv
// ----------------------------------------------------------------------------
// Torque peak-hold scaler package
// Shared argument bundle and fixed scaling constants.
// ----------------------------------------------------------------------------
package tphs_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MV_NUM     = 3301;
  localparam int MV_SHIFT   = 12;
  localparam int EXCESS_MAX = 1500;
  // 2^30 / 1501 rounded up; exact for products below 2^19
  localparam int RECIP_MUL  = 715351;
  localparam int RECIP_SHIFT = 30;

  typedef struct packed {
    logic        enable;
    logic        gear_active;
    logic [7:0]  gear_ceiling;
    logic [7:0]  output_floor;
    logic [11:0] offset_mv;
  } scale_args_t;

endpackage

// File: rtl/tphs_cell.sv
// ----------------------------------------------------------------------------
// Torque peak-hold window cell
// Holds one stored sample and passes a running peak and remaining length
// on to its older neighbor every cycle.
// ----------------------------------------------------------------------------
module tphs_cell #(
  parameter int CW = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic [tphs_pkg::SAMPLE_W-1:0] sample_in,
  output logic [tphs_pkg::SAMPLE_W-1:0] sample_out,
  input  logic [tphs_pkg::SAMPLE_W-1:0] peak_in,
  output logic [tphs_pkg::SAMPLE_W-1:0] peak_out,
  input  logic [CW-1:0]                 count_in,
  output logic [CW-1:0]                 count_out
);

  logic [tphs_pkg::SAMPLE_W-1:0] stored;
  logic [tphs_pkg::SAMPLE_W-1:0] peak;
  logic [CW-1:0]                 count;
  logic                          live;

  assign live = (count_in != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else if (shift) begin
      stored <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    peak  <= (live && (stored > peak_in)) ? stored : peak_in;
    count <= live ? count_in - CW'(1) : count_in;
  end

  assign sample_out = stored;
  assign peak_out   = peak;
  assign count_out  = count;

endmodule

// File: rtl/tphs_scale.sv
// ----------------------------------------------------------------------------
// Torque peak-hold scaler arithmetic
// Six-stage pipeline: millivolt scaling, offset and clamp, linear map,
// reciprocal product, quotient by 1501, floor add.
// ----------------------------------------------------------------------------
module tphs_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tphs_pkg::SAMPLE_W-1:0] peak,
  input  tphs_pkg::scale_args_t         args,
  output logic                          done,
  output logic [7:0]                    drive
);

  logic [5:0]         stage_v;
  logic [23:0]        mv_prod;
  logic [12:0]        excess;
  logic [10:0]        mv_clamp;
  logic               pass2;
  logic               pass3;
  logic               pass4;
  logic signed [8:0]  span;
  logic signed [20:0] map_prod;
  logic [18:0]        map_mag;
  logic               neg4;
  logic               neg5;
  logic [38:0]        quot_prod;
  logic [8:0]         quot;
  logic               pass5;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      stage_v <= {stage_v[4:0], start};
    end
  end

  assign excess = {1'b0, mv_prod[23:tphs_pkg::MV_SHIFT]} - {1'b0, args.offset_mv};
  assign span   = $signed({1'b0, args.gear_ceiling}) - $signed({1'b0, args.output_floor});
  assign map_prod = $signed({1'b0, mv_clamp}) * span;

  always_ff @(posedge clk) begin
    mv_prod  <= {12'b0, peak} * 24'(tphs_pkg::MV_NUM);
    pass2    <= args.enable && args.gear_active && !excess[12];
    mv_clamp <= (excess > 13'(tphs_pkg::EXCESS_MAX)) ? 11'(tphs_pkg::EXCESS_MAX)
                                                     : excess[10:0];
    pass3    <= pass2;
    neg4     <= map_prod[20];
    map_mag  <= map_prod[20] ? 19'(-map_prod) : map_prod[18:0];
    pass4    <= pass3;
    quot_prod <= {20'b0, map_mag} * 39'(tphs_pkg::RECIP_MUL);
    neg5     <= neg4;
    pass5    <= pass4;
    quot     <= quot_prod[38:tphs_pkg::RECIP_SHIFT];
    if (!pass5) begin
      drive <= '0;
    end else if (neg5) begin
      drive <= args.output_floor - quot[7:0];
    end else begin
      drive <= args.output_floor + quot[7:0];
    end
  end

  // stage_v[0] marks mv_prod, [1] clamp, [2] magnitude, [3] product, [4] quotient,
  // [5] drive
  assign done = stage_v[5];

endmodule

// File: rtl/torque_peak_hold_scaler.sv
// ----------------------------------------------------------------------------
// Torque peak-hold scaler
// Each accepted sample beat updates a window of recent nonzero samples,
// finds the peak of the newest window_length entries and maps it to a drive.
// ----------------------------------------------------------------------------
// One input beat at a time: a new sample beat is taken only once the result of
// the last one has reached the output register. Each result comes from the
// walk of the peak token down the row of window cells, one cell per cycle,
// then the six-stage scaling pipeline and the output register load. A finished
// result waits in the output register while the next sample beat is accepted;
// the scaling of that next beat starts once the waiting result is taken.
// Window length saturates at WINDOW_DEPTH.
// ----------------------------------------------------------------------------
module torque_peak_hold_scaler #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] sample,
  input  logic        gear_active,
  input  logic [7:0]  gear_ceiling,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  drive,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int LW = (CW > 6) ? CW : 6;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_FLOOR  = 2'd3;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_CALC  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [CW-1:0] sweep_count;
  logic        enable;
  logic [5:0]  window_length;
  logic [11:0] offset_mv;
  logic [7:0]  output_floor;
  logic        cur_gear_active;
  logic [7:0]  cur_gear_ceiling;
  logic        in_take;
  logic        shift;
  logic        start;
  logic        done;
  logic [7:0]  scaled_drive;
  logic [LW-1:0] len_ext;
  logic [CW-1:0] len_sat;
  tphs_pkg::scale_args_t args;

  logic [tphs_pkg::SAMPLE_W-1:0] smp_chain  [WINDOW_DEPTH];
  logic [tphs_pkg::SAMPLE_W-1:0] peak_chain [WINDOW_DEPTH];
  logic [CW-1:0]                 cnt_chain  [WINDOW_DEPTH];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign shift     = in_take && (sample != '0);
  assign start     = (state == ST_WAIT) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      window_length <= 6'd32;
      offset_mv     <= '0;
      output_floor  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE: enable        <= cfg_data[0];
        REG_LENGTH: window_length <= cfg_data[5:0];
        REG_OFFSET: offset_mv     <= cfg_data;
        REG_FLOOR:  output_floor  <= cfg_data[7:0];
      endcase
    end
  end

  assign len_ext = LW'(window_length);
  assign len_sat = (len_ext > LW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : CW'(len_ext);

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
      if (gi == WINDOW_DEPTH - 1) begin : g_top
        tphs_cell #(.CW(CW)) u_cell (
          .clk        (clk),
          .rst        (rst),
          .shift      (shift),
          .sample_in  (sample),
          .sample_out (smp_chain[gi]),
          .peak_in    ('0),
          .peak_out   (peak_chain[gi]),
          .count_in   (len_sat),
          .count_out  (cnt_chain[gi])
        );
      end else begin : g_mid
        tphs_cell #(.CW(CW)) u_cell (
          .clk        (clk),
          .rst        (rst),
          .shift      (shift),
          .sample_in  (smp_chain[gi+1]),
          .sample_out (smp_chain[gi]),
          .peak_in    (peak_chain[gi+1]),
          .peak_out   (peak_chain[gi]),
          .count_in   (cnt_chain[gi+1]),
          .count_out  (cnt_chain[gi])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_gear_active  <= gear_active;
      cur_gear_ceiling <= gear_ceiling;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_take) state_next = ST_SWEEP;
      ST_SWEEP: if (sweep_count == CW'(WINDOW_DEPTH - 1)) state_next = ST_WAIT;
      ST_WAIT:  if (start) state_next = ST_CALC;
      ST_CALC:  if (done) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sweep_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_count <= sweep_count + CW'(1);
      end else begin
        sweep_count <= '0;
      end
    end
  end

  assign args.enable       = enable;
  assign args.gear_active  = cur_gear_active;
  assign args.gear_ceiling = cur_gear_ceiling;
  assign args.output_floor = output_floor;
  assign args.offset_mv    = offset_mv;

  tphs_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .peak  (peak_chain[0]),
    .args  (args),
    .done  (done),
    .drive (scaled_drive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      drive <= scaled_drive;
    end
  end

endmodule

// File: rtl/tphs_checker.sv
// ----------------------------------------------------------------------------
// Torque peak-hold scaler port checker
// Watches the ports of the top level for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module tphs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  drive
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample beat taken while one is in flight");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result beat raised without freeing the input");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result beat raised in the cycle after a sample beat");

endmodule

bind torque_peak_hold_scaler tphs_checker u_tphs_checker (.*);
